// ===== hdl/sha1civ_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 core with
// programmable initial chaining words. No dependencies.
package sha1civ_pkg;

   // Reset values of the initial chaining words
   localparam logic [31:0] IV_A_RESET = 32'h98BADCFE;
   localparam logic [31:0] IV_B_RESET = 32'hC3D2E1F0;
   localparam logic [31:0] IV_C_RESET = 32'h67452301;
   localparam logic [31:0] IV_D_RESET = 32'h10325476;
   localparam logic [31:0] IV_E_RESET = 32'hEFCDAB89;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_INIT_A = 3'd0;
   localparam logic [2:0] CSR_INIT_B = 3'd1;
   localparam logic [2:0] CSR_INIT_C = 3'd2;
   localparam logic [2:0] CSR_INIT_D = 3'd3;
   localparam logic [2:0] CSR_INIT_E = 3'd4;

   // Block geometry and padding
   localparam logic [5:0] BLOCK_LAST = 6'd63;
   localparam logic [5:0] LEN_START  = 6'd56;
   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [6:0] GRP1_START = 7'd20;
   localparam logic [6:0] GRP2_START = 7'd40;
   localparam logic [6:0] GRP3_START = 7'd60;
   localparam logic [2:0] WORD_LAST  = 3'd4;

   // Round constants
   localparam logic [31:0] K_CH  = 32'h5A827999;
   localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
   localparam logic [31:0] K_P2  = 32'hCA62C1D6;

   typedef enum logic [1:0] {
      GRP_CH     = 2'd0,
      GRP_PARITY = 2'd1,
      GRP_MAJ    = 2'd2,
      GRP_LAST   = 2'd3
   } grp_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       no_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   typedef logic [4:0][31:0] words5_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic       byte_en;     // absorb byte_val
      logic [7:0] byte_val;
      logic       word_push;   // byte completes a 32-bit word
      logic       chain_init;  // load chain from initial words
      logic       round_start; // load working vars from chain
      logic       round_en;    // run one round
      grp_type    grp;
      logic       chain_add;   // fold working vars into chain
      logic       chain_shift; // rotate chain for digest output
   } ctrl_type;

   function automatic logic [31:0] round_f(grp_type grp, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
      logic [31:0] r;
      case (grp)
         GRP_CH:  r = (b & c) | (~b & d);
         GRP_MAJ: r = (b & c) | (b & d) | (c & d);
         default: r = b ^ c ^ d;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(grp_type grp);
      logic [31:0] r;
      case (grp)
         GRP_CH:     r = K_CH;
         GRP_PARITY: r = K_P1;
         GRP_MAJ:    r = K_MAJ;
         default:    r = K_P2;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/sha1civ_compress.sv =====
// SHA-1 compression datapath: word packer, 16-word schedule shift line,
// one shared round unit and the chaining words. Uses sha1civ_pkg.
module sha1civ_compress (
   input  logic                   clock,
   input  sha1civ_pkg::ctrl_type  ctrl,
   input  sha1civ_pkg::words5_type init_words,
   output logic [31:0]            digest_word
);

   logic [23:0] acc_ff, acc_in;
   logic [15:0][31:0] sched_ff, sched_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [4:0][31:0] chain_ff, chain_in;
   logic [31:0] w_new, x_sched, t_sum;

   // Round arithmetic on the shared unit
   always_comb begin
      x_sched = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      w_new   = {x_sched[30:0], x_sched[31]};
      t_sum   = {a_ff[26:0], a_ff[31:27]}
              + sha1civ_pkg::round_f(ctrl.grp, b_ff, c_ff, d_ff)
              + e_ff + sha1civ_pkg::round_k(ctrl.grp) + sched_ff[0];
   end

   // Byte packer and schedule line
   always_comb begin
      acc_in   = acc_ff;
      sched_in = sched_ff;
      if (ctrl.byte_en) begin
         acc_in = {acc_ff[15:0], ctrl.byte_val};
      end
      if (ctrl.byte_en && ctrl.word_push) begin
         sched_in = {acc_ff, ctrl.byte_val, sched_ff[15:1]};
      end else if (ctrl.round_en) begin
         sched_in = {w_new, sched_ff[15:1]};
      end
   end

   // Working variables
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (ctrl.round_start) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (ctrl.round_en) begin
         a_in = t_sum;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   // Chaining words
   always_comb begin
      chain_in = chain_ff;
      if (ctrl.chain_init) begin
         chain_in = init_words;
      end else if (ctrl.chain_add) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end else if (ctrl.chain_shift) begin
         chain_in = {chain_ff[0], chain_ff[4:1]};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      sched_ff <= sched_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      chain_ff <= chain_in;
   end

   assign digest_word = chain_ff[0];

endmodule

// ===== hdl/sha1_hash_custom_iv_core.sv =====
// SHA-1 core with programmable initial chaining words: top level with
// sequencer, padding and csr registers. Uses sha1civ_pkg, sha1civ_compress.
//
// Takes a message one byte per item and returns the 160-bit SHA-1 digest as
// five 32-bit words, most significant first, digest_last on the fifth. The
// byte that completes a 64-byte block starts a compression: 80 rounds on the
// single round unit plus one chain update. An end_of_message item is
// followed by padding at one byte per cycle up to the block end, one or two
// compressions, and the five digest words. The csr words init_word_a..e are
// loaded into the chain when a message starts, so a write during a message
// applies from the next one; indexes above 4 are ignored.
module sha1_hash_custom_iv_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sha1civ_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sha1civ_pkg::rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);

   sha1civ_pkg::state_type  state_ff, state_in;
   sha1civ_pkg::words5_type init_ff, init_in;
   sha1civ_pkg::ctrl_type   ctrl;
   logic [5:0]  idx_ff, idx_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  out_ff, out_in;
   logic [63:0] len_ff, len_in, len_sh;
   logic        open_ff, open_in;
   logic        fin_ff, fin_in;
   logic        mark_ff, mark_in;
   logic        wrap_ff, wrap_in;
   logic        lastblk_ff, lastblk_in;
   logic        accept, has_byte, pad_len;
   logic [31:0] digest_word;

   assign req_stall = (state_ff != sha1civ_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign has_byte  = !req_data.no_byte;
   assign rsp_valid = (state_ff == sha1civ_pkg::ST_OUT);
   assign rsp_data.digest_word = digest_word;
   assign rsp_data.digest_last = (out_ff == sha1civ_pkg::WORD_LAST);

   // Length byte for the current block position, most significant first
   assign len_sh  = len_ff >> {3'(~idx_ff[2:0]), 3'b000};
   assign pad_len = mark_ff && (idx_ff >= sha1civ_pkg::LEN_START) && !wrap_ff;

   // csr registers
   always_comb begin
      init_in = init_ff;
      if (csr_we) begin
         case (csr_index)
            sha1civ_pkg::CSR_INIT_A: init_in[0] = csr_wdata;
            sha1civ_pkg::CSR_INIT_B: init_in[1] = csr_wdata;
            sha1civ_pkg::CSR_INIT_C: init_in[2] = csr_wdata;
            sha1civ_pkg::CSR_INIT_D: init_in[3] = csr_wdata;
            sha1civ_pkg::CSR_INIT_E: init_in[4] = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      rnd_in     = rnd_ff;
      out_in     = out_ff;
      len_in     = len_ff;
      open_in    = open_ff;
      fin_in     = fin_ff;
      mark_in    = mark_ff;
      wrap_in    = wrap_ff;
      lastblk_in = lastblk_ff;
      ctrl       = '0;

      if (rnd_ff < sha1civ_pkg::GRP1_START) begin
         ctrl.grp = sha1civ_pkg::GRP_CH;
      end else if (rnd_ff < sha1civ_pkg::GRP2_START) begin
         ctrl.grp = sha1civ_pkg::GRP_PARITY;
      end else if (rnd_ff < sha1civ_pkg::GRP3_START) begin
         ctrl.grp = sha1civ_pkg::GRP_MAJ;
      end else begin
         ctrl.grp = sha1civ_pkg::GRP_LAST;
      end

      case (state_ff)
         sha1civ_pkg::ST_IDLE: begin
            if (accept && (has_byte || req_data.end_of_message)) begin
               if (!open_ff) begin
                  ctrl.chain_init = 1'b1;
                  open_in = 1'b1;
                  len_in  = '0;
               end
               if (has_byte) begin
                  ctrl.byte_en   = 1'b1;
                  ctrl.byte_val  = req_data.data_byte;
                  ctrl.word_push = (idx_ff[1:0] == 2'b11);
                  idx_in = idx_ff + 6'd1;
                  len_in = (open_ff ? len_ff : 64'd0) + 64'd8;
               end
               fin_in = req_data.end_of_message;
               if (has_byte && idx_ff == sha1civ_pkg::BLOCK_LAST) begin
                  ctrl.round_start = 1'b1;
                  rnd_in   = '0;
                  state_in = sha1civ_pkg::ST_ROUND;
               end else if (req_data.end_of_message) begin
                  state_in = sha1civ_pkg::ST_PAD;
               end
            end
         end
         sha1civ_pkg::ST_PAD: begin
            // one pad byte per cycle: marker, zeros, then the bit length
            ctrl.byte_en   = 1'b1;
            ctrl.word_push = (idx_ff[1:0] == 2'b11);
            if (!mark_ff) begin
               ctrl.byte_val = sha1civ_pkg::PAD_MARK;
            end else if (pad_len) begin
               ctrl.byte_val = len_sh[7:0];
            end else begin
               ctrl.byte_val = 8'h00;
            end
            mark_in = 1'b1;
            idx_in  = idx_ff + 6'd1;
            if (!mark_ff && idx_ff >= sha1civ_pkg::LEN_START) begin
               wrap_in = 1'b1;
            end
            if (idx_ff == sha1civ_pkg::BLOCK_LAST) begin
               wrap_in          = 1'b0;
               lastblk_in       = pad_len;
               ctrl.round_start = 1'b1;
               rnd_in           = '0;
               state_in         = sha1civ_pkg::ST_ROUND;
            end
         end
         sha1civ_pkg::ST_ROUND: begin
            ctrl.round_en = 1'b1;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == sha1civ_pkg::ROUND_LAST) begin
               state_in = sha1civ_pkg::ST_ADD;
            end
         end
         sha1civ_pkg::ST_ADD: begin
            ctrl.chain_add = 1'b1;
            if (!fin_ff) begin
               state_in = sha1civ_pkg::ST_IDLE;
            end else if (lastblk_ff) begin
               out_in   = '0;
               state_in = sha1civ_pkg::ST_OUT;
            end else begin
               state_in = sha1civ_pkg::ST_PAD;
            end
         end
         sha1civ_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               ctrl.chain_shift = 1'b1;
               out_in = out_ff + 3'd1;
               if (out_ff == sha1civ_pkg::WORD_LAST) begin
                  open_in    = 1'b0;
                  fin_in     = 1'b0;
                  mark_in    = 1'b0;
                  lastblk_in = 1'b0;
                  len_in     = '0;
                  state_in   = sha1civ_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha1civ_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha1civ_pkg::ST_IDLE;
         init_ff    <= {sha1civ_pkg::IV_E_RESET, sha1civ_pkg::IV_D_RESET,
                        sha1civ_pkg::IV_C_RESET, sha1civ_pkg::IV_B_RESET,
                        sha1civ_pkg::IV_A_RESET};
         idx_ff     <= '0;
         rnd_ff     <= '0;
         out_ff     <= '0;
         len_ff     <= '0;
         open_ff    <= 1'b0;
         fin_ff     <= 1'b0;
         mark_ff    <= 1'b0;
         wrap_ff    <= 1'b0;
         lastblk_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         init_ff    <= init_in;
         idx_ff     <= idx_in;
         rnd_ff     <= rnd_in;
         out_ff     <= out_in;
         len_ff     <= len_in;
         open_ff    <= open_in;
         fin_ff     <= fin_in;
         mark_ff    <= mark_in;
         wrap_ff    <= wrap_in;
         lastblk_ff <= lastblk_in;
      end
   end

   sha1civ_compress u_compress (
      .clock       (clock),
      .ctrl        (ctrl),
      .init_words  (init_ff),
      .digest_word (digest_word)
   );

   // A block compression starts only when the last byte of a block goes in
   a_round_start: assert property (@(posedge clock) disable iff (reset)
      ctrl.round_start |-> ctrl.byte_en && idx_ff == sha1civ_pkg::BLOCK_LAST)
      else $error("compression started off a block boundary");

   // Digest output only after the final padded block, with the block empty
   a_out_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fin_ff && open_ff && lastblk_ff && idx_ff == 6'd0)
      else $error("digest output without a finished message");

   // The round counter never runs past the last round
   a_round_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1civ_pkg::ST_ROUND |-> rnd_ff <= sha1civ_pkg::ROUND_LAST)
      else $error("round counter overran");

   // After the last digest word is taken the block is idle and closed
   a_out_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.digest_last |=> !rsp_valid && !open_ff)
      else $error("message not closed after last digest word");

   // Padding never starts with the length bytes before the marker byte
   a_pad_order: assert property (@(posedge clock) disable iff (reset)
      pad_len |-> mark_ff && !wrap_ff)
      else $error("length bytes before pad marker");

endmodule

// ===== test/tb.sv =====
// Testbench for sha1_hash_custom_iv_core: byte-serial SHA-1 with programmable
// initial chaining words, checked against an in-bench digest predictor.
// Depends on sha1civ_pkg and the core only.
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 300;   // pad + two compressions + output
   localparam int LONG_HOLD    = 600;
   localparam logic [2:0] CSR_UNUSED_LO = 3'd5;

   localparam logic [2:0] IV_INDEX [5] = '{sha1civ_pkg::CSR_INIT_A,
                                           sha1civ_pkg::CSR_INIT_B,
                                           sha1civ_pkg::CSR_INIT_C,
                                           sha1civ_pkg::CSR_INIT_D,
                                           sha1civ_pkg::CSR_INIT_E};
   // Message lengths where the padding lands on or across a block edge
   localparam int EDGE_LENS [6] = '{55, 56, 57, 63, 64, 65};

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sha1civ_pkg::req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sha1civ_pkg::rsp_type rsp_data;
   logic                 csr_we    = 1'b0;
   logic [2:0]           csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   sha1_hash_custom_iv_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: shadow of the csr words and of the hash context
   logic [31:0] iv_regs [5] = '{sha1civ_pkg::IV_A_RESET, sha1civ_pkg::IV_B_RESET,
                                sha1civ_pkg::IV_C_RESET, sha1civ_pkg::IV_D_RESET,
                                sha1civ_pkg::IV_E_RESET};
   logic [31:0] chain [5];
   logic [7:0]  blk [64];
   logic [63:0] msg_bits  = '0;
   bit          msg_open  = 1'b0;

   sha1civ_pkg::req_type pending_q [$];   // items waiting to be offered
   sha1civ_pkg::rsp_type digest_q [$];    // digest words still owed by the core

   int  err_count     = 0;
   int  words_checked = 0;
   int  items_taken   = 0;
   int  msgs_closed   = 0;
   int  iv_sets       = 1;
   int  cycle_count   = 0;

   // Sender pacing
   bit  req_taken  = 1'b0;
   int  burst_left = 0;
   int  gap_left   = 0;

   // Receiver pacing
   bit          long_hold_req = 1'b0;
   int          hold_left     = 0;
   int          pat_age       = 0;
   logic [15:0] stall_pat     = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // One 80-round compression of blk into chain
   task automatic sha_compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = sha1civ_pkg::K_CH;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = sha1civ_pkg::K_P1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1civ_pkg::K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = sha1civ_pkg::K_P2;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endtask

   // Advance the hash context by one accepted item, queue any digest words
   task automatic predict_digest(sha1civ_pkg::req_type it);
      int idx;
      if (it.no_byte && !it.end_of_message)
         return;
      if (!msg_open) begin
         chain    = iv_regs;
         msg_bits = '0;
         msg_open = 1'b1;
      end
      if (!it.no_byte) begin
         idx = int'(msg_bits[8:3]);
         blk[idx] = it.data_byte;
         msg_bits += 64'd8;
         if (idx == sha1civ_pkg::BLOCK_LAST)
            sha_compress();
      end
      if (!it.end_of_message)
         return;
      // pad: marker byte, zeros, big-endian bit count
      idx = int'(msg_bits[8:3]);
      blk[idx] = sha1civ_pkg::PAD_MARK;
      idx++;
      if (idx > sha1civ_pkg::LEN_START) begin
         while (idx < 64) begin
            blk[idx] = 8'h00;
            idx++;
         end
         sha_compress();
         idx = 0;
      end
      while (idx < sha1civ_pkg::LEN_START) begin
         blk[idx] = 8'h00;
         idx++;
      end
      for (int i = 0; i < 8; i++)
         blk[sha1civ_pkg::LEN_START + i] = msg_bits[63 - 8*i -: 8];
      sha_compress();
      for (int i = 0; i < 5; i++)
         digest_q.push_back('{digest_word: chain[i], digest_last: (i == 4)});
      msg_open = 1'b0;
      msgs_closed++;
   endtask

   function automatic void note_mismatch(string what, logic [31:0] want,
                                         logic [31:0] got);
      err_count++;
      if (err_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endfunction

   // Driver, accept side: an item leaves the queue on its handshake edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_digest(req_data);
         void'(pending_q.pop_front());
         items_taken++;
         req_taken = 1'b1;
      end
   end

   // Driver, offer side: bursts of items with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_taken = 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled item stays on the bus unchanged
      end else begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_q[0];
            if (burst_left > 0)
               burst_left--;
            else begin
               burst_left = $urandom_range(0, 30);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else
            req_valid <= 1'b0;
      end
   end

   // Receiver: rotating stall pattern, reshuffled now and then, plus long hold-off
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left     = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (pat_age == 0) begin
            pat_age = $urandom_range(20, 100);
            case ($urandom_range(0, 3))
               0:       stall_pat = '0;
               1:       stall_pat = 16'($urandom);
               2:       stall_pat = 16'($urandom & $urandom);
               default: stall_pat = 16'($urandom | $urandom);
            endcase
         end else begin
            pat_age--;
            stall_pat = {stall_pat[14:0], stall_pat[15]};
         end
         rsp_stall <= stall_pat[0];
      end
   end

   // Monitor: each digest word against the oldest expectation
   always @(posedge clock) begin
      sha1civ_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_q.size() == 0)
            note_mismatch("unexpected digest word", '0, rsp_data.digest_word);
         else begin
            want = digest_q.pop_front();
            words_checked++;
            if (rsp_data.digest_word !== want.digest_word)
               note_mismatch("digest_word", want.digest_word, rsp_data.digest_word);
            if (rsp_data.digest_last !== want.digest_last)
               note_mismatch("digest_last", 32'(want.digest_last),
                             32'(rsp_data.digest_last));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digest words owed",
                  cycle_count, digest_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void push_item(logic [7:0] data, logic no_byte, logic eom);
      pending_q.push_back('{data_byte: data, no_byte: no_byte, end_of_message: eom});
   endfunction

   // Queue one message; returns the number of meaningful items queued
   function automatic int queue_message(int len, bit close);
      bit sep_end;
      int n;
      n = 0;
      sep_end = (len == 0) || ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            push_item(8'($urandom), 1'b1, 1'b0);   // empty item, ignored
         push_item(8'($urandom), 1'b0, close && !sep_end && (i == len - 1));
         n++;
      end
      if (close && sep_end) begin
         push_item(8'($urandom), 1'b1, 1'b1);
         n++;
      end
      return n;
   endfunction

   function automatic void queue_random(int target);
      int got, len, r;
      got = 0;
      while (got < target) begin
         r = $urandom_range(0, 99);
         if (r < 65)
            len = $urandom_range(0, 20);
         else if (r < 90)
            len = $urandom_range(21, 70);
         else
            len = EDGE_LENS[$urandom_range(0, 5)];
         // keep the phase close to its item budget
         if (len > target - got)
            len = target - got;
         got += queue_message(len, 1'b1);
      end
   endfunction

   // Block is idle: nothing queued, nothing offered, nothing owed, then drain
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || digest_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write all five iv words, then one write to an unused index
   task automatic load_ivs(sha1civ_pkg::words5_type v);
      for (int i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= IV_INDEX[i];
         csr_wdata <= v[i];
         iv_regs[i] = v[i];
      end
      @(negedge clock);
      csr_index <= 3'(CSR_UNUSED_LO + $urandom_range(0, 2));
      csr_wdata <= $urandom;
      @(negedge clock);
      csr_we <= 1'b0;
      iv_sets++;
   endtask

   function automatic sha1civ_pkg::words5_type random_ivs();
      sha1civ_pkg::words5_type v;
      for (int i = 0; i < 5; i++)
         v[i] = $urandom;
      return v;
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset iv: empty message, single bytes, short messages
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'hFF, 1'b0, 1'b1);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(8'h80, 1'b0, 1'b0);
      push_item(8'h7F, 1'b0, 1'b0);
      push_item(8'hAA, 1'b1, 1'b1);
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'h61, 1'b0, 1'b0);
      push_item(8'h55, 1'b1, 1'b0);
      push_item(8'h62, 1'b0, 1'b0);
      push_item(8'h63, 1'b0, 1'b1);
      push_item(8'hFF, 1'b1, 1'b1);
      wait_idle();

      // All-zero iv
      load_ivs('0);
      void'(queue_message(0, 1'b1));
      queue_random(15);
      wait_idle();

      // All-ones iv while the receiver holds off for a long stretch
      load_ivs('1);
      long_hold_req = 1'b1;
      void'(queue_message(0, 1'b1));
      queue_random(20);
      wait_idle();

      // Standard SHA-1 iv
      load_ivs({32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89,
                32'h67452301});
      queue_random(15);
      wait_idle();

      // iv rewritten while a message is open: applies from the next message
      void'(queue_message($urandom_range(60, 70), 1'b0));
      wait_idle();
      load_ivs(random_ivs());
      push_item(8'($urandom), 1'b1, 1'b1);
      queue_random(15);
      wait_idle();

      // Random iv
      load_ivs(random_ivs());
      queue_random(45);
      wait_idle();

      $display("%0d items accepted, %0d messages closed under %0d iv settings",
               items_taken, msgs_closed, iv_sets);
      $display("%0d digest words checked, %0d mismatches", words_checked, err_count);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
